@@ sv/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package spq_pkg;

   localparam int SPQ_CAPACITY = 16;
   localparam int VALUE_W      = 32;
   localparam int PRIO_W       = 16;
   localparam int STATUS_W     = 2;
   localparam int OCC_W        = 5;

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         priority_key;
   } entry_type;

   // Operation broadcast to every cell of the chain.
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type new_entry;
   } ctrl_type;

endpackage

@@ sv/spq_cell.sv @@
// One storage cell of the sorted chain: holds an entry and trades with its neighbors.
module spq_cell (
   input  logic               clock,
   input  spq_pkg::ctrl_type  ctrl,
   input  logic               occupied,
   input  logic               left_ins,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output logic               ins,
   output spq_pkg::entry_type entry
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // The new entry lands at or before this cell when this cell is free or
   // holds a priority not smaller than the new one.
   assign ins = ctrl.enq && (!occupied || (ctrl.new_entry.priority_key <= entry_ff.priority_key));

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.enq && ins) begin
         entry_in = left_ins ? left_entry : ctrl.new_entry;
      end else if (ctrl.deq) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ sv/sorted_priority_queue.sv @@
// Sorted priority queue top level: cell chain, fill count and result register.
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle while each response is taken (req_ready); every
// cell compares against the new key in parallel and shifts one place.
// Reset empties the queue and clears rsp_valid; entries and result fields are kept.
module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic signed [spq_pkg::VALUE_W-1:0]  req_item_value,
   input  logic [spq_pkg::PRIO_W-1:0]          req_item_priority,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [spq_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [spq_pkg::VALUE_W-1:0]  rsp_head_value,
   output logic [spq_pkg::PRIO_W-1:0]          rsp_head_priority,
   output logic [spq_pkg::OCC_W-1:0]           rsp_occupancy
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic              rsp_valid_ff;
   status_type        status_ff;
   status_type        status_in;
   entry_type         head_ff;
   entry_type         head_in;
   logic [OCC_W-1:0]  occ_ff;
   logic [CW+OCC_W-1:0] count_ext;

   logic              accept;
   logic              full;
   logic              empty;
   ctrl_type          ctrl;
   logic              ins_chain [CAPACITY];
   entry_type         entries   [CAPACITY];

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);

   assign ctrl.enq                    = accept && (req_cmd == CMD_ENQ) && !full;
   assign ctrl.deq                    = accept && (req_cmd == CMD_DEQ) && !empty;
   assign ctrl.new_entry.value        = req_item_value;
   assign ctrl.new_entry.priority_key = req_item_priority;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      occupied;
      logic      left_ins;
      entry_type left_entry;
      entry_type right_entry;

      assign occupied = (count_ff > CW'(i));

      if (i == 0) begin : g_first
         assign left_ins   = 1'b0;
         assign left_entry = entries[0];
      end else begin : g_mid
         assign left_ins   = ins_chain[i-1];
         assign left_entry = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entries[i];
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .left_ins    (left_ins),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .ins         (ins_chain[i]),
         .entry       (entries[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = ST_DONE;
      head_in   = '0;
      if (ctrl.enq) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.deq) begin
         count_in = count_ff - CW'(1);
         head_in  = entries[0];
      end
      if (req_cmd == CMD_ENQ && full) begin
         status_in = ST_FULL;
      end else if (req_cmd == CMD_DEQ && empty) begin
         status_in = ST_EMPTY;
      end
   end

   assign count_ext = {{OCC_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         status_ff <= status_in;
         head_ff   <= head_in;
         occ_ff    <= count_ext[OCC_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_head_value    = head_ff.value;
   assign rsp_head_priority = head_ff.priority_key;
   assign rsp_occupancy     = occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.deq |=> count_ff == $past(count_ff) - CW'(1))
      else $error("dequeue did not reduce the count by one");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_ENQ && full |=> count_ff == $past(count_ff))
      else $error("enqueue into a full queue changed the count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(2) |-> entries[0].priority_key <= entries[1].priority_key)
      else $error("head entry out of order");

endmodule
